@@ hw/rtl/pcbdc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcbdc_pkg - shared types and constants for the preconnect duty clamp
// Register indexes, field widths and the sideband record that travels through
// the divider pipeline next to each sample.
// ----------------------------------------------------------------------------
package pcbdc_pkg;

	// default full-scale duty, hundredths of a percent
	localparam int DUTY_FULL_SCALE = 10000;

	// field widths
	localparam int MV_W     = 16;
	localparam int DUTY_W   = 16;
	localparam int CFGD_W   = 14;
	localparam int COUNT_W  = 2;
	localparam int IDX_W    = 3;
	localparam int CFG_W    = 16;
	// width of duty bounds plus headroom before capping
	localparam int BOUND_W  = CFGD_W + 1;

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_TARGET_MV      = 3'd0,
		REG_PRECONNECT_EN  = 3'd1,
		REG_DUTY_MIN       = 3'd2,
		REG_DUTY_MAX       = 3'd3,
		REG_HEADROOM       = 3'd4,
		REG_COAST_MARGIN   = 3'd5
	} reg_idx_t;

	// per-sample record carried alongside the division
	typedef struct packed {
		logic                     no_ideal;   // vin or target zero, or vin >= target
		logic                     coast;      // vout at or above target plus margin
		logic signed [DUTY_W-1:0] duty;       // proposed loop duty
	} side_t;

endpackage

@@ hw/rtl/preconnect_boost_duty_clamp_unit.sv @@
// ----------------------------------------------------------------------------
// preconnect_boost_duty_clamp_unit - preconnect floor and ceiling duty clamp
// Usage:
//   Samples arrive on the s_ stream; each gives exactly one result on the m_
//   stream, in order. While preconnect is enabled the loop duty is raised to a
//   floor and lowered to a ceiling, both derived from the ideal boost duty
//   (target - vin) * full scale / target; otherwise it passes unchanged.
//   decay_count says how many clamps fired (0 to 2).
//   Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data). The
//   user must write it only while no sample is in flight; the block does not enforce this.
// Pipeline:
//   One input stage, one multiply stage, one divider stage per quotient bit,
//   one bound stage and the output register. A new sample is taken every
//   cycle while the result stream is not stalled.
// Reset:
//   arst_n empties the pipeline and loads the register defaults.
// Stall:
//   When m_tready is low with a result waiting, the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module preconnect_boost_duty_clamp_unit #(
	parameter int DUTY_FULL_SCALE = pcbdc_pkg::DUTY_FULL_SCALE
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// sample stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [47:0]                       s_tdata,  // vin_mv, vout_mv, proposed_duty
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [23:0]                       m_tdata,  // limited_duty, decay_count, zero pad
	// configuration writes
	input  logic                              cfg_wr_en,
	input  logic [pcbdc_pkg::IDX_W-1:0]       cfg_index,
	input  logic [pcbdc_pkg::CFG_W-1:0]       cfg_data
);

	localparam int MV_W   = pcbdc_pkg::MV_W;
	localparam int DUTY_W = pcbdc_pkg::DUTY_W;
	localparam int CD_W   = pcbdc_pkg::CFGD_W;
	localparam int BW     = pcbdc_pkg::BOUND_W;
	localparam int CNT_W  = pcbdc_pkg::COUNT_W;
	localparam int QW     = $clog2(DUTY_FULL_SCALE);
	localparam int NW     = MV_W + $clog2(DUTY_FULL_SCALE + 1);
	localparam logic [NW-1:0] FS_W = NW'(DUTY_FULL_SCALE);

	// clamp v into [lo, hi], lower bound tested first
	function automatic logic [BW-1:0] range_clamp(input logic [BW-1:0] v,
		input logic [BW-1:0] lo, input logic [BW-1:0] hi);
		logic [BW-1:0] r;
		if (v < lo) begin
			r = lo;
		end else if (v > hi) begin
			r = hi;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// configuration registers
	logic [MV_W-1:0] target_q;
	logic            enable_q;
	logic [CD_W-1:0] min_q;
	logic [CD_W-1:0] max_q;
	logic [CD_W-1:0] head_q;
	logic [MV_W-1:0] margin_q;

	// pipeline control
	logic en;
	logic out_vld_q;

	// stage 1: flags and difference
	logic                     vld_s1;
	logic [MV_W-1:0]          diff_s1;
	pcbdc_pkg::side_t         side_s1;

	// stage 2: numerator
	logic                     vld_s2;
	logic [NW-1:0]            num_s2;
	pcbdc_pkg::side_t         side_s2;

	// divider output
	logic                     vld_sd;
	logic [QW-1:0]            quo_sd;
	pcbdc_pkg::side_t         side_sd;

	// stage 3: bounds
	logic                     vld_s3;
	logic [BW-1:0]            lo_s3;
	logic [BW-1:0]            hi_s3;
	logic signed [DUTY_W-1:0] duty_s3;

	// output register
	logic signed [DUTY_W-1:0] duty_q;
	logic [CNT_W-1:0]         count_q;

	// input field views
	logic [MV_W-1:0]          vin;
	logic [MV_W-1:0]          vout;
	logic signed [DUTY_W-1:0] pduty;

	assign vin   = s_tdata[15:0];
	assign vout  = s_tdata[31:16];
	assign pduty = signed'(s_tdata[47:32]);

	// whole pipeline advances unless a result is held
	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			enable_q <= 1'b0;
			min_q    <= CD_W'(200);
			max_q    <= CD_W'(9000);
			head_q   <= '0;
			margin_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (pcbdc_pkg::reg_idx_t'(cfg_index))
				pcbdc_pkg::REG_TARGET_MV:     target_q <= cfg_data[MV_W-1:0];
				pcbdc_pkg::REG_PRECONNECT_EN: enable_q <= cfg_data[0];
				pcbdc_pkg::REG_DUTY_MIN:      min_q    <= cfg_data[CD_W-1:0];
				pcbdc_pkg::REG_DUTY_MAX:      max_q    <= cfg_data[CD_W-1:0];
				pcbdc_pkg::REG_HEADROOM:      head_q   <= cfg_data[CD_W-1:0];
				pcbdc_pkg::REG_COAST_MARGIN:  margin_q <= cfg_data[MV_W-1:0];
				default: ;
			endcase
		end
	end

	// valid bits of the local stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s1    <= s_tvalid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_sd;
			out_vld_q <= vld_s3;
		end
	end

	// stage 1: classify the sample and form target - vin
	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1          <= target_q - vin;
			side_s1.no_ideal <= (vin == '0) || (target_q == '0) || (vin >= target_q);
			side_s1.coast    <= {1'b0, vout} >= ({1'b0, target_q} + {1'b0, margin_q});
			side_s1.duty     <= pduty;
		end
	end

	// stage 2: scale the difference by full scale
	always_ff @(posedge clk) begin
		if (en) begin
			num_s2  <= NW'(diff_s1) * FS_W;
			side_s2 <= side_s1;
		end
	end

	pcbdc_div #(
		.NW (NW),
		.QW (QW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s2),
		.in_num   (num_s2),
		.in_dvs   (target_q),
		.in_side  (side_s2),
		.out_vld  (vld_sd),
		.out_quo  (quo_sd),
		.out_side (side_sd)
	);

	// stage 3: floor and ceiling from the ideal duty
	logic [BW-1:0] ideal;
	logic [BW-1:0] min_w;
	logic [BW-1:0] max_w;
	logic [BW-1:0] boosted;
	logic [BW-1:0] capped;
	logic [BW-1:0] lo_d;
	logic [BW-1:0] hi_d;

	always_comb begin
		ideal   = BW'(quo_sd);
		min_w   = BW'(min_q);
		max_w   = BW'(max_q);
		boosted = ideal + BW'(head_q);
		capped  = (boosted > max_w) ? max_w : boosted;
		if (side_sd.no_ideal || side_sd.coast) begin
			lo_d = min_w;
		end else begin
			lo_d = range_clamp(ideal, min_w, max_w);
		end
		if (side_sd.no_ideal) begin
			hi_d = max_w;
		end else begin
			hi_d = range_clamp(capped, min_w, max_w);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s3   <= lo_d;
			hi_s3   <= hi_d;
			duty_s3 <= side_sd.duty;
		end
	end

	// stage 4: apply floor then ceiling, count the clamps
	logic signed [DUTY_W-1:0] lo_sg;
	logic signed [DUTY_W-1:0] hi_sg;
	logic signed [DUTY_W-1:0] after_lo;
	logic signed [DUTY_W-1:0] after_hi;
	logic                     lo_hit;
	logic                     hi_hit;

	always_comb begin
		lo_sg    = signed'(DUTY_W'(lo_s3));
		hi_sg    = signed'(DUTY_W'(hi_s3));
		lo_hit   = enable_q && (duty_s3 < lo_sg);
		after_lo = lo_hit ? lo_sg : duty_s3;
		hi_hit   = enable_q && (after_lo > hi_sg);
		after_hi = hi_hit ? hi_sg : after_lo;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			duty_q  <= after_hi;
			count_q <= CNT_W'(lo_hit) + CNT_W'(hi_hit);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {6'b0, count_q, duty_q};

	// at most two clamps can fire
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> count_q != 2'd3)
		else $error("decay count out of range");

	// an accepted sample always enters the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> vld_s1)
		else $error("accepted sample not captured");

	// a stalled result stays valid and unchanged
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

endmodule

@@ hw/rtl/pcbdc_div.sv @@
// ----------------------------------------------------------------------------
// pcbdc_div - pipelined restoring divider
// One quotient bit per register stage, most significant first. The quotient
// must fit in QW bits; the caller guarantees numerator < divisor << QW.
// ----------------------------------------------------------------------------
module pcbdc_div #(
	parameter int NW = 30,
	parameter int QW = 14
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_vld,
	input  logic [NW-1:0]                   in_num,
	input  logic [pcbdc_pkg::MV_W-1:0]      in_dvs,
	input  pcbdc_pkg::side_t                in_side,
	output logic                            out_vld,
	output logic [QW-1:0]                   out_quo,
	output pcbdc_pkg::side_t                out_side
);

	localparam int DW = pcbdc_pkg::MV_W;

	// stage registers, one entry per quotient bit
	logic [NW-1:0]          rem_s  [QW];
	logic [QW-1:0]          quo_s  [QW];
	logic [DW-1:0]          dvs_s  [QW];
	pcbdc_pkg::side_t       side_s [QW];
	logic [QW-1:0]          vld_s;

	for (genvar i = 0; i < QW; i++) begin : g_stage
		localparam int SH = QW - 1 - i;

		logic [NW-1:0]    cur_rem;
		logic [QW-1:0]    cur_quo;
		logic [DW-1:0]    cur_dvs;
		pcbdc_pkg::side_t cur_side;
		logic             cur_vld;
		logic [NW:0]      trial;
		logic             fits;

		// pick the previous stage, or the ports for the first one
		if (i == 0) begin : g_first
			assign cur_rem  = in_num;
			assign cur_quo  = '0;
			assign cur_dvs  = in_dvs;
			assign cur_side = in_side;
			assign cur_vld  = in_vld;
		end else begin : g_next
			assign cur_rem  = rem_s[i-1];
			assign cur_quo  = quo_s[i-1];
			assign cur_dvs  = dvs_s[i-1];
			assign cur_side = side_s[i-1];
			assign cur_vld  = vld_s[i-1];
		end

		// compare the remainder against the shifted divisor
		assign trial = {{(NW+1-DW){1'b0}}, cur_dvs} << SH;
		assign fits  = {1'b0, cur_rem} >= trial;

		// advance the valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= cur_vld;
			end
		end

		// subtract when the divisor fits and set the quotient bit
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= fits ? NW'({1'b0, cur_rem} - trial) : cur_rem;
				quo_s[i]  <= cur_quo | (fits ? (QW'(1) << SH) : '0);
				dvs_s[i]  <= cur_dvs;
				side_s[i] <= cur_side;
			end
		end
	end

	assign out_vld  = vld_s[QW-1];
	assign out_quo  = quo_s[QW-1];
	assign out_side = side_s[QW-1];

	// a stalled pipeline keeps every valid bit
	a_hold_vld: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s))
		else $error("divider valid bits moved during stall");

	// a finished division leaves a remainder below the divisor
	a_rem_low: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[QW-1] && !side_s[QW-1].no_ideal |->
			rem_s[QW-1] < NW'(dvs_s[QW-1]))
		else $error("divider remainder not below divisor");

	// a stalled quotient stays in place
	a_hold_quo: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[QW-1] && !en |=> vld_s[QW-1] && $stable(quo_s[QW-1]))
		else $error("divider quotient moved during stall");

endmodule
